FILE: rtl/dns_blacklist_substring_matcher_macros.svh
// Assertion helpers for the blacklist matcher.
`ifndef DNS_BLACKLIST_SUBSTRING_MATCHER_MACROS_SVH
`define DNS_BLACKLIST_SUBSTRING_MATCHER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define DBSM_ASSERT_NOW(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("dbsm: property violated");

// Next-cycle implication, disabled in reset.
`define DBSM_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("dbsm: property violated");

`endif

FILE: rtl/dbsm_pkg.sv
`default_nettype none

package dbsm_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int MAX_LEN_DEF = 64;

    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_PATTERN = 2'd1;
    localparam logic [1:0] CMD_PACKET  = 2'd2;

    // broadcast to every cell of the row
    typedef struct packed {
        logic       step;
        logic       kill;
        logic       clr;
        logic [7:0] feed;
        logic [7:0] wr_byte;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/dbsm_ifs.sv
`default_nettype none

interface dbsm_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [3:0] entry_index;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output cmd, output entry_index, output data_byte,
                    output last_byte, input ready);
    modport sink   (input valid, input cmd, input entry_index, input data_byte,
                    input last_byte, output ready);
endinterface

interface dbsm_result_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, output hit, input ready);
    modport sink   (input valid, input hit, output ready);
endinterface

`default_nettype wire

FILE: rtl/dbsm_cell.sv
`default_nettype none

module dbsm_cell #(
    parameter int ENTRIES = dbsm_pkg::ENTRIES_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dbsm_pkg::cell_ctrl_t ctrl,
    input  wire logic                 wr_sel,
    input  wire logic [ENTRIES-1:0]   wr_row,
    input  wire logic [ENTRIES-1:0]   d_prev,
    input  wire logic [7:0]           win_prev,
    input  wire logic [ENTRIES-1:0]   end_mask,
    output logic      [ENTRIES-1:0]   d_out,
    output logic      [7:0]           win_out,
    output logic                      hit
);

    logic [7:0]         store_mem [ENTRIES];
    logic [ENTRIES-1:0] d_reg;
    logic [ENTRIES-1:0] d_next;
    logic [7:0]         win_reg;
    logic               hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_sel)
        begin
            for (int e = 0; e < ENTRIES; e++)
            begin
                if (wr_row[e])
                begin
                    store_mem[e] <= ctrl.wr_byte;
                end
            end
        end
    end

    // prefix ending at this position extends the one from the left neighbor
    always_comb
    begin
        for (int e = 0; e < ENTRIES; e++)
        begin
            d_next[e] = !ctrl.kill && d_prev[e] && (store_mem[e] == ctrl.feed);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_reg   <= '0;
            win_reg <= '0;
            hit_reg <= 1'b0;
        end
        else if (ctrl.step)
        begin
            hit_reg <= |(d_next & end_mask);
            d_reg   <= ctrl.clr ? '0 : d_next;
            win_reg <= ctrl.clr ? 8'd0 : win_prev;
        end
    end

    assign d_out   = d_reg;
    assign win_out = win_reg;
    assign hit     = hit_reg;

endmodule

`default_nettype wire

FILE: rtl/dns_blacklist_substring_matcher.sv
`default_nettype none
`include "dns_blacklist_substring_matcher_macros.svh"

// Blacklist substring matcher. Pattern bytes (cmd 1), table clears (cmd 0) and
// packet bytes (cmd 2) arrive as items; packet bytes stream at one per cycle
// through a row of MAX_LEN cells, each holding one byte position of every
// pattern, one window byte and the per-entry prefix-match bits handed to the
// next cell. The hit is folded from the cell hits while the last packet byte
// sits in the step register, then is registered as the result transaction. When
// a pattern byte has been written while a packet is in progress, the next packet
// byte waits while the row replays the window against the updated table. Input
// also stalls while a hit transaction waits on result and the next packet's
// final byte is pending behind it. No clearing pass is needed after reset.

module dns_blacklist_substring_matcher #(
    parameter int ENTRIES = dbsm_pkg::ENTRIES_DEF,
    parameter int MAX_LEN = dbsm_pkg::MAX_LEN_DEF
) (
    input wire logic     clk,
    input wire logic     rst_n,
    dbsm_item_if.sink    item,
    dbsm_result_if.source result
);

    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_REPLAY = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [LW-1:0]       lp_reg, lp_next;
    logic [LW-1:0]       len_reg [ENTRIES];
    logic [LW-1:0]       count_reg, count_next;
    logic [PW-1:0]       rc_reg, rc_next;
    logic                dirty_reg, dirty_next;
    logic                match_reg, match_next;
    logic                step_v_reg, step_v_next;
    logic                step_last_reg, step_last_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_hit_reg, out_hit_next;

    dbsm_pkg::cell_ctrl_t ctrl;
    logic [ENTRIES-1:0]  d_out [MAX_LEN];
    logic [7:0]          win_out [MAX_LEN];
    logic [MAX_LEN-1:0]  cell_hit;
    logic [ENTRIES-1:0]  wr_row;
    logic [EW-1:0]       eidx;
    logic [LW-1:0]       lp_after;
    logic [LW-1:0]       thr;

    logic fold_stall, fold_go, want_replay, item_ready, acc;
    logic pkt_step, pat_go, wr_do, clr_go, entry_ok, fold_match;

    assign fold_stall  = step_v_reg && step_last_reg && out_valid_reg && !result.ready;
    assign fold_go     = step_v_reg && !fold_stall;
    assign want_replay = dirty_reg && item.valid && (item.cmd == dbsm_pkg::CMD_PACKET)
                         && (count_reg != '0);
    assign item_ready  = (state_reg == S_IDLE) && !fold_stall && !want_replay;
    assign item.ready  = item_ready;
    assign acc         = item.valid && item_ready;

    assign entry_ok = ({5'd0, item.entry_index} < 9'(ENTRIES));
    assign eidx     = EW'(item.entry_index);
    assign pkt_step = acc && (item.cmd == dbsm_pkg::CMD_PACKET);
    assign clr_go   = acc && (item.cmd == dbsm_pkg::CMD_CLEAR);
    assign pat_go   = acc && (item.cmd == dbsm_pkg::CMD_PATTERN) && entry_ok;
    assign wr_do    = pat_go && (lp_reg < LW'(MAX_LEN));
    assign lp_after = wr_do ? lp_reg + LW'(1) : lp_reg;
    assign thr      = LW'(MAX_LEN) - count_reg;

    always_comb
    begin
        ctrl.step    = pkt_step || (state_reg == S_REPLAY);
        ctrl.kill    = (state_reg == S_REPLAY) && (LW'(rc_reg) < thr);
        ctrl.clr     = pkt_step && item.last_byte;
        ctrl.feed    = (state_reg == S_REPLAY) ? win_out[MAX_LEN-1] : item.data_byte;
        ctrl.wr_byte = item.data_byte;
    end

    for (genvar e = 0; e < ENTRIES; e++)
    begin : g_row
        assign wr_row[e] = (eidx == EW'(e));
    end

    for (genvar k = 0; k < MAX_LEN; k++)
    begin : g_cell
        logic [ENTRIES-1:0] d_in;
        logic [ENTRIES-1:0] end_mask;
        logic [7:0]         win_in;
        logic               wr_sel;

        for (genvar e = 0; e < ENTRIES; e++)
        begin : g_end
            assign end_mask[e] = (len_reg[e] == LW'(k + 1));
        end

        if (k == 0)
        begin : g_head
            assign d_in   = '1;
            assign win_in = ctrl.feed;
        end
        else
        begin : g_body
            assign d_in   = d_out[k-1];
            assign win_in = win_out[k-1];
        end

        assign wr_sel = wr_do && (lp_reg[PW-1:0] == PW'(k));

        dbsm_cell #(
            .ENTRIES (ENTRIES)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .wr_sel   (wr_sel),
            .wr_row   (wr_row),
            .d_prev   (d_in),
            .win_prev (win_in),
            .end_mask (end_mask),
            .d_out    (d_out[k]),
            .win_out  (win_out[k]),
            .hit      (cell_hit[k])
        );
    end

    assign fold_match = match_reg || (|cell_hit);

    always_comb
    begin
        state_next     = state_reg;
        rc_next        = rc_reg;
        dirty_next     = dirty_reg;
        lp_next        = lp_reg;
        count_next     = count_reg;
        match_next     = match_reg;
        step_v_next    = step_v_reg;
        step_last_next = step_last_reg;
        out_valid_next = out_valid_reg;
        out_hit_next   = out_hit_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (want_replay && !fold_stall)
                begin
                    state_next = S_REPLAY;
                    rc_next    = '0;
                    dirty_next = 1'b0;
                end
            end
            S_REPLAY:
            begin
                rc_next = rc_reg + PW'(1);
                if (rc_reg == PW'(MAX_LEN - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (wr_do)
        begin
            dirty_next = 1'b1;
        end
        else if (pkt_step)
        begin
            dirty_next = 1'b0;
        end

        if (clr_go)
        begin
            lp_next = '0;
        end
        else if (pat_go)
        begin
            lp_next = item.last_byte ? '0 : lp_after;
        end

        if (pkt_step)
        begin
            if (item.last_byte)
            begin
                count_next = '0;
            end
            else if (count_reg < LW'(MAX_LEN))
            begin
                count_next = count_reg + LW'(1);
            end
        end

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (fold_go)
        begin
            if (step_last_reg)
            begin
                out_valid_next = 1'b1;
                out_hit_next   = fold_match;
                match_next     = 1'b0;
            end
            else
            begin
                match_next = fold_match;
            end
        end

        if (!fold_stall)
        begin
            step_v_next    = pkt_step;
            step_last_next = item.last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rc_reg        <= '0;
            dirty_reg     <= 1'b0;
            lp_reg        <= '0;
            count_reg     <= '0;
            match_reg     <= 1'b0;
            step_v_reg    <= 1'b0;
            step_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rc_reg        <= rc_next;
            dirty_reg     <= dirty_next;
            lp_reg        <= lp_next;
            count_reg     <= count_next;
            match_reg     <= match_next;
            step_v_reg    <= step_v_next;
            step_last_reg <= step_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_hit_reg <= out_hit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < ENTRIES; e++)
            begin
                len_reg[e] <= '0;
            end
        end
        else if (clr_go)
        begin
            for (int e = 0; e < ENTRIES; e++)
            begin
                len_reg[e] <= '0;
            end
        end
        else if (pat_go)
        begin
            if (item.last_byte)
            begin
                len_reg[eidx] <= lp_after;
            end
            else if (lp_reg == '0)
            begin
                len_reg[eidx] <= '0;
            end
        end
    end

    assign result.valid = out_valid_reg;
    assign result.hit   = out_hit_reg;

    `DBSM_ASSERT_NOW(a_result_from_fold, clk, rst_n, $rose(out_valid_reg), $past(fold_go && step_last_reg))
    `DBSM_ASSERT_NOW(a_replay_clean, clk, rst_n, state_reg == S_REPLAY, !dirty_reg && !item.ready)
    `DBSM_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= LW'(MAX_LEN) && lp_reg <= LW'(MAX_LEN))
    `DBSM_ASSERT_NEXT(a_stall_holds, clk, rst_n, fold_stall, step_v_reg && step_last_reg && out_valid_reg)

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int N_ENT = dbsm_pkg::ENTRIES_DEF;
    localparam int N_LEN = dbsm_pkg::MAX_LEN_DEF;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS = 600;

    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] entry_index;
        logic [7:0] data_byte;
        logic       last_byte;
    } txn_t;

    logic clk = 1'b0;
    logic rst_n;

    dbsm_item_if   item_bus();
    dbsm_result_if result_bus();

    dns_blacklist_substring_matcher uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus)
    );

    always #5 clk = ~clk;

    txn_t        pending[$];
    bit          expected_hits[$];
    int unsigned sent_count;
    int unsigned cycle_count;
    int unsigned fail_count;
    int unsigned total_queued;
    int unsigned hold_left;
    bit          hold_done;

    // predictor state
    bit [7:0]    tbl_bytes [N_ENT][N_LEN];
    int unsigned tbl_len [N_ENT];
    int unsigned tbl_fill_pos;
    bit [7:0]    pkt_window [N_LEN];
    int unsigned pkt_seen;
    bit          pkt_hit;

    // stimulus planner's view of the pattern table
    bit [7:0]    plan_bytes [N_ENT][N_LEN];
    bit          plan_written [N_ENT][N_LEN];
    int unsigned plan_len [N_ENT];
    int unsigned plan_pos;
    int unsigned plan_items;

    function automatic int unsigned phase();
        return (sent_count / 100) % 4;
    endfunction

    function automatic bit sender_idle();
        case (phase())
            1: return $urandom_range(99) < 57;
            3: return $urandom_range(99) < 12;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (phase())
            2: return $urandom_range(99) < 57;
            3: return $urandom_range(99) < 12;
            default: return 1'b0;
        endcase
    endfunction

    task automatic log_failure(string what);
        fail_count++;
        if (fail_count <= 10)
            $display("ERROR @%0t: %s", $time, what);
    endtask

    task automatic predict_packet_hit(logic [1:0] c, logic [3:0] e, logic [7:0] b, logic l);
        int unsigned len;
        bit same;
        case (c)
            dbsm_pkg::CMD_CLEAR:
            begin
                foreach (tbl_len[i])
                    tbl_len[i] = 0;
                tbl_fill_pos = 0;
            end
            dbsm_pkg::CMD_PATTERN:
            begin
                if (tbl_fill_pos == 0)
                    tbl_len[e] = 0;
                if (tbl_fill_pos < N_LEN)
                begin
                    tbl_bytes[e][tbl_fill_pos] = b;
                    tbl_fill_pos++;
                end
                if (l)
                begin
                    tbl_len[e] = tbl_fill_pos;
                    tbl_fill_pos = 0;
                end
            end
            dbsm_pkg::CMD_PACKET:
            begin
                for (int k = N_LEN - 1; k > 0; k--)
                    pkt_window[k] = pkt_window[k - 1];
                pkt_window[0] = b;
                if (pkt_seen < N_LEN)
                    pkt_seen++;
                for (int x = 0; x < N_ENT; x++)
                begin
                    len = tbl_len[x];
                    if (len > 0 && len <= pkt_seen)
                    begin
                        same = 1'b1;
                        for (int k = 0; k < len; k++)
                            if (tbl_bytes[x][k] != pkt_window[len - 1 - k])
                                same = 1'b0;
                        if (same)
                            pkt_hit = 1'b1;
                    end
                end
                if (l)
                begin
                    expected_hits.push_back(pkt_hit);
                    pkt_seen = 0;
                    pkt_hit = 1'b0;
                    foreach (pkt_window[k])
                        pkt_window[k] = 8'h00;
                end
            end
            default: ;
        endcase
    endtask

    task automatic queue_item(logic [1:0] c, logic [3:0] e, logic [7:0] b, logic l);
        txn_t t;
        t.cmd = c;
        t.entry_index = e;
        t.data_byte = b;
        t.last_byte = l;
        pending.push_back(t);
        total_queued++;
        if (c != CMD_UNUSED)
            plan_items++;
        if (c == dbsm_pkg::CMD_CLEAR)
        begin
            foreach (plan_len[i])
                plan_len[i] = 0;
            plan_pos = 0;
        end
        else if (c == dbsm_pkg::CMD_PATTERN)
        begin
            if (plan_pos == 0)
                plan_len[e] = 0;
            if (plan_pos < N_LEN)
            begin
                plan_bytes[e][plan_pos] = b;
                plan_written[e][plan_pos] = 1'b1;
                plan_pos++;
            end
            if (l)
            begin
                plan_len[e] = plan_pos;
                plan_pos = 0;
            end
        end
    endtask

    function automatic bit prefix_written(int e, int unsigned n);
        for (int k = 0; k < n; k++)
            if (!plan_written[e][k])
                return 1'b0;
        return 1'b1;
    endfunction

    // mostly a small alphabet so that accidental matches occur
    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 45)
            return 8'(8'h61 + $urandom_range(3));
        else if (r < 60)
            return 8'($urandom_range(3));
        return 8'($urandom_range(255));
    endfunction

    function automatic int unsigned pattern_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(6, 1);
        else if (r < 90)
            return $urandom_range(20, 7);
        else if (r < 97)
            return $urandom_range(64, 21);
        return $urandom_range(72, 65);
    endfunction

    function automatic int unsigned packet_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            return $urandom_range(8, 1);
        else if (r < 90)
            return $urandom_range(30, 9);
        return $urandom_range(80, 31);
    endfunction

    // closing byte must name an entry whose lower bytes are all written
    task automatic load_pattern(int unsigned n, bit close, bit may_switch);
        int x;
        int s;
        int cand;
        int unsigned p;
        bit fin;
        bit found;
        x = $urandom_range(N_ENT - 1);
        for (int i = 0; i < n; i++)
        begin
            fin = close && (i == n - 1);
            if (may_switch && i > 0 && $urandom_range(99) < 15)
                x = $urandom_range(N_ENT - 1);
            if (fin)
            begin
                p = (plan_pos < N_LEN) ? plan_pos : N_LEN;
                if (!prefix_written(x, p))
                begin
                    found = 1'b0;
                    s = $urandom_range(N_ENT - 1);
                    for (int j = 0; j < N_ENT; j++)
                    begin
                        cand = (s + j) % N_ENT;
                        if (!found && prefix_written(cand, p))
                        begin
                            x = cand;
                            found = 1'b1;
                        end
                    end
                    if (!found)
                        queue_item(dbsm_pkg::CMD_CLEAR, 4'($urandom_range(15)),
                                   8'($urandom_range(255)), 1'b0);
                end
            end
            queue_item(dbsm_pkg::CMD_PATTERN, 4'(x), pick_byte(), fin);
        end
    endtask

    task automatic send_packet(int unsigned n);
        bit [7:0] body[$];
        int cands[$];
        int e;
        int unsigned plen;
        int unsigned off;
        for (int i = 0; i < n; i++)
            body.push_back(pick_byte());
        for (int i = 0; i < N_ENT; i++)
            if (plan_len[i] > 0)
                cands.push_back(i);
        if (cands.size() > 0 && $urandom_range(99) < 70)
        begin
            e = cands[$urandom_range(cands.size() - 1)];
            plen = plan_len[e];
            if ($urandom_range(99) < 80)
            begin
                while (body.size() < plen)
                    body.push_back(pick_byte());
                off = $urandom_range(body.size() - plen);
            end
            else
                off = $urandom_range(body.size() - 1);
            for (int k = 0; k < plen; k++)
                if (off + k < body.size())
                    body[off + k] = plan_bytes[e][k];
        end
        for (int i = 0; i < body.size(); i++)
        begin
            if (i > 0 && $urandom_range(99) < 3)
            begin
                if ($urandom_range(99) < 30)
                    queue_item(dbsm_pkg::CMD_CLEAR, 4'($urandom_range(15)),
                               8'($urandom_range(255)), 1'b0);
                else
                    load_pattern($urandom_range(4, 1), 1'b1, 1'b0);
            end
            queue_item(dbsm_pkg::CMD_PACKET, 4'($urandom_range(15)), body[i],
                       i == body.size() - 1);
        end
    endtask

    task automatic plan_directed();
        queue_item(dbsm_pkg::CMD_PACKET, 4'hF, 8'hAA, 1'b1);
        queue_item(dbsm_pkg::CMD_PATTERN, 4'hF, 8'hFF, 1'b1);
        queue_item(dbsm_pkg::CMD_PACKET, 4'h0, 8'h00, 1'b0);
        queue_item(dbsm_pkg::CMD_PACKET, 4'h0, 8'hFF, 1'b1);
        queue_item(dbsm_pkg::CMD_PATTERN, 4'h0, 8'h00, 1'b0);
        queue_item(dbsm_pkg::CMD_PATTERN, 4'h0, 8'h01, 1'b1);
        // pattern would run past the packet end
        queue_item(dbsm_pkg::CMD_PACKET, 4'h0, 8'h00, 1'b1);
        queue_item(dbsm_pkg::CMD_PACKET, 4'h0, 8'h00, 1'b0);
        queue_item(dbsm_pkg::CMD_PACKET, 4'h0, 8'h01, 1'b1);
        // entry switched mid-load
        queue_item(dbsm_pkg::CMD_PATTERN, 4'h1, 8'h10, 1'b0);
        queue_item(dbsm_pkg::CMD_PATTERN, 4'h0, 8'h11, 1'b1);
        queue_item(CMD_UNUSED, 4'hF, 8'hFF, 1'b1);
        queue_item(dbsm_pkg::CMD_PACKET, 4'h0, 8'h00, 1'b0);
        queue_item(dbsm_pkg::CMD_PACKET, 4'h0, 8'h11, 1'b1);
        // table change mid-packet
        queue_item(dbsm_pkg::CMD_PACKET, 4'h0, 8'h33, 1'b0);
        queue_item(dbsm_pkg::CMD_PATTERN, 4'h2, 8'h33, 1'b1);
        queue_item(dbsm_pkg::CMD_PACKET, 4'h0, 8'h33, 1'b1);
        // clear mid-packet keeps the earlier match
        queue_item(dbsm_pkg::CMD_PACKET, 4'h0, 8'hFF, 1'b0);
        queue_item(dbsm_pkg::CMD_CLEAR, 4'h0, 8'h00, 1'b0);
        queue_item(dbsm_pkg::CMD_PACKET, 4'h0, 8'hFF, 1'b1);
        queue_item(dbsm_pkg::CMD_PACKET, 4'h0, 8'hFF, 1'b1);
        // open load abandoned by a clear
        queue_item(dbsm_pkg::CMD_PATTERN, 4'h5, 8'h7F, 1'b0);
        queue_item(dbsm_pkg::CMD_CLEAR, 4'h0, 8'h00, 1'b0);
        queue_item(dbsm_pkg::CMD_PATTERN, 4'h5, 8'h7F, 1'b1);
    endtask

    task automatic plan_random();
        int unsigned r;
        // overlong pattern first, then a packet long enough to hold it
        load_pattern(70, 1'b1, 1'b0);
        send_packet(72);
        while (plan_items < RANDOM_ITEMS)
        begin
            r = $urandom_range(99);
            if (r < 8)
                queue_item(dbsm_pkg::CMD_CLEAR, 4'($urandom_range(15)),
                           8'($urandom_range(255)), 1'($urandom_range(1)));
            else if (r < 30)
                load_pattern(pattern_size(), 1'b1, $urandom_range(99) < 25);
            else if (r < 35)
                load_pattern($urandom_range(3, 1), 1'b0, 1'b0);
            else if (r < 40)
                queue_item(CMD_UNUSED, 4'($urandom_range(15)),
                           8'($urandom_range(255)), 1'($urandom_range(1)));
            else
                send_packet(packet_size());
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        txn_t nxt;
        if (!rst_n)
        begin
            item_bus.valid       <= 1'b0;
            item_bus.cmd         <= dbsm_pkg::CMD_CLEAR;
            item_bus.entry_index <= 4'h0;
            item_bus.data_byte   <= 8'h00;
            item_bus.last_byte   <= 1'b0;
            sent_count           <= 0;
        end
        else
        begin
            if (item_bus.valid && item_bus.ready)
                sent_count <= sent_count + 1;
            if (!item_bus.valid || item_bus.ready)
            begin
                if (pending.size() > 0 && !sender_idle())
                begin
                    nxt = pending.pop_front();
                    item_bus.cmd         <= nxt.cmd;
                    item_bus.entry_index <= nxt.entry_index;
                    item_bus.data_byte   <= nxt.data_byte;
                    item_bus.last_byte   <= nxt.last_byte;
                    item_bus.valid       <= 1'b1;
                end
                else
                    item_bus.valid <= 1'b0;
            end
        end
    end

    // long hold-off once, early in the unthrottled phase
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
            hold_left        <= 0;
            hold_done        <= 1'b0;
        end
        else if (!hold_done && sent_count >= 60)
        begin
            hold_left        <= HOLD_CYCLES;
            hold_done        <= 1'b1;
            result_bus.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left        <= hold_left - 1;
            result_bus.ready <= 1'b0;
        end
        else
            result_bus.ready <= !receiver_stall();
    end

    always @(posedge clk)
    begin
        bit want;
        if (rst_n)
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                if (expected_hits.size() == 0)
                    log_failure($sformatf("unexpected result, hit=%0b", result_bus.hit));
                else
                begin
                    want = expected_hits.pop_front();
                    if (result_bus.hit !== want)
                        log_failure($sformatf("hit expected %0b, got %0b",
                                              want, result_bus.hit));
                end
            end
            if (item_bus.valid && item_bus.ready)
                predict_packet_hit(item_bus.cmd, item_bus.entry_index,
                                   item_bus.data_byte, item_bus.last_byte);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        plan_directed();
        plan_random();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        while (sent_count != total_queued)
            @(posedge clk);
        while (expected_hits.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: dns_blacklist_substring_matcher.f
+incdir+rtl
rtl/dbsm_pkg.sv
rtl/dbsm_ifs.sv
rtl/dbsm_cell.sv
rtl/dns_blacklist_substring_matcher.sv
verif/tb_top.sv
